// File: design/kclp_pkg.sv
// ----------------------------------------------------------------------------
// kclp_pkg - shared types and constants of the keyed command line parser
// Character codes, key table, field widths and the tracker status struct.
// ----------------------------------------------------------------------------
`default_nettype none

package kclp_pkg;

  // default limits
  localparam int LINE_LIMIT_DEF  = 100;
  localparam int FIELD_LIMIT_DEF = 19;

  // fixed widths
  localparam int CHAR_W = 8;
  localparam int POS_W  = 7;
  localparam int MAG_W  = 9;
  localparam int NKEYS  = 4;
  localparam int PRS_W  = 8;

  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;
  localparam logic [PRS_W-1:0] PRS_MAX = '1;
  localparam logic [PRS_W-1:0] PRS_RESET = '1;

  // key indexes
  localparam int KEY_H = 0;
  localparam int KEY_R = 1;
  localparam int KEY_S = 2;
  localparam int KEY_A = 3;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

  // key characters H, R, S, A
  localparam logic [CHAR_W-1:0] KEY_CODE [NKEYS] = '{8'h48, 8'h52, 8'h53, 8'h41};

  // field phase codes
  typedef enum logic [2:0] {
    PH_LEAD = 3'b001,
    PH_DIG  = 3'b010,
    PH_DONE = 3'b100
  } kclp_phase_t;

  // status of one key tracker
  typedef struct packed {
    logic             seen;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } kclp_field_t;

endpackage

`default_nettype wire

// File: design/kclp_field_tracker.sv
// ----------------------------------------------------------------------------
// kclp_field_tracker - per-key field scanner
// Finds the first occurrence of a key and reads the signed decimal after it.
// ----------------------------------------------------------------------------
`default_nettype none

module kclp_field_tracker #(
  parameter int FIELD_LIMIT = kclp_pkg::FIELD_LIMIT_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              step,
  input  wire                              clear,
  input  wire  [kclp_pkg::CHAR_W-1:0]      ch,
  input  wire  [kclp_pkg::CHAR_W-1:0]      key_code,
  output kclp_pkg::kclp_field_t            status
);
  import kclp_pkg::*;

  localparam int LEN_W = $clog2(FIELD_LIMIT + 1);
  localparam int ACC_W = MAG_W + 4;

  logic             seen_r, seen_nxt;
  kclp_phase_t      phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  logic             is_digit, is_blank;
  logic [ACC_W-1:0] acc;

  // character classes and digit accumulation
  always_comb begin
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    acc = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0} + ACC_W'(ch - CH_ZERO);
  end

  // next state of the scanner
  always_comb begin
    seen_nxt  = seen_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    len_nxt   = len_r;
    if (clear) begin
      seen_nxt  = 1'b0;
      phase_nxt = PH_LEAD;
      neg_nxt   = 1'b0;
      mag_nxt   = '0;
      len_nxt   = '0;
    end else if (step) begin
      if (!seen_r) begin
        seen_nxt = (ch == key_code);
      end else if ((phase_r == PH_DONE) || (len_r >= LEN_W'(FIELD_LIMIT))) begin
        phase_nxt = PH_DONE;
      end else begin
        len_nxt = len_r + 1'b1;
        if (ch == CH_COMMA) begin
          phase_nxt = PH_DONE;
        end else if ((phase_r == PH_LEAD) && is_blank) begin
          phase_nxt = PH_LEAD;
        end else if ((phase_r == PH_LEAD) && ((ch == CH_PLUS) || (ch == CH_MINUS))) begin
          neg_nxt   = (ch == CH_MINUS);
          phase_nxt = PH_DIG;
        end else if (is_digit) begin
          phase_nxt = PH_DIG;
          mag_nxt   = (acc > ACC_W'(MAG_MAX)) ? MAG_MAX : acc[MAG_W-1:0];
        end else begin
          phase_nxt = PH_DONE;
        end
      end
    end
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      phase_r <= PH_LEAD;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      len_r   <= '0;
    end else begin
      seen_r  <= seen_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      len_r   <= len_nxt;
    end
  end

  assign status.seen = seen_r;
  assign status.neg  = neg_r;
  assign status.mag  = mag_r;

  // field scan checks
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(FIELD_LIMIT)) else $error("field length beyond limit");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> !seen_r && (mag_r == '0) && (len_r == '0))
    else $error("tracker not cleared at line end");
  a_unseen_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> (len_r == '0) && (mag_r == '0))
    else $error("field read before key seen");

endmodule

`default_nettype wire

// File: design/keyed_command_line_parser_unit.sv
// ----------------------------------------------------------------------------
// keyed_command_line_parser_unit - serial command line decoder
// Reads H, R, S and A fields from a character stream and reports per line.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received character per request in in_tdata[7:0]. A '%' or
//           NUL ends the command line.
//   out_* : one result request per line end; out_tdata lists from bit 0
//           handshake_ok, data_request, pressure_updated, pressure_command.
//   Every character is taken into an input register, then updates the four
//   key trackers (or forms the line result) into the result register, so a
//   result is presented once its line-end character has left the input register.
//   Throughput is one character per cycle while no line end waits on a held
//   result, set by the tracker update between input register and tracker state.
//   When the receiver stalls, ordinary characters keep flowing; a further
//   line end waits in the input register until the held result is taken.
//   Reset empties both registers, clears the line state and sets the
//   pressure setting to 255.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_command_line_parser_unit #(
  parameter int LINE_LIMIT  = kclp_pkg::LINE_LIMIT_DEF,
  parameter int FIELD_LIMIT = kclp_pkg::FIELD_LIMIT_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] rx_char
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata   // [0] handshake_ok, [1] data_request,
                                  // [2] pressure_updated, [10:3] pressure_command
);
  import kclp_pkg::*;

  // input register
  logic              s_vld_r, s_vld_nxt;
  logic [CHAR_W-1:0] s_char_r;
  logic              s_end, s_go, in_fire;

  // line position and pressure
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [PRS_W-1:0]  press_r, press_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              hs_r, rq_r, upd_r;
  logic              hs_nxt, rq_nxt, upd_nxt;

  logic              trk_step, trk_clear;
  kclp_field_t       fld [NKEYS];

  // handshake and stage advance
  always_comb begin
    s_end     = (s_char_r == CH_PERCENT) || (s_char_r == CH_NUL);
    s_go      = s_vld_r && (!s_end || !out_valid_r || out_tready);
    in_tready = !s_vld_r || s_go;
    in_fire   = in_tvalid && in_tready;
    s_vld_nxt = in_fire ? 1'b1 : (s_go ? 1'b0 : s_vld_r);
    trk_step  = s_go && !s_end && (pos_r < POS_W'(LINE_LIMIT));
    trk_clear = s_go && s_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= s_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_char_r <= in_tdata[CHAR_W-1:0];
    end
  end

  // key trackers
  for (genvar k = 0; k < NKEYS; k++) begin : g_trk
    kclp_field_tracker #(
      .FIELD_LIMIT (FIELD_LIMIT)
    ) u_trk (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (trk_step),
      .clear    (trk_clear),
      .ch       (s_char_r),
      .key_code (KEY_CODE[k]),
      .status   (fld[k])
    );
  end

  // line result and pressure update
  always_comb begin
    hs_nxt  = fld[KEY_H].seen && (fld[KEY_H].mag == '0);
    rq_nxt  = fld[KEY_R].seen && (fld[KEY_R].mag == '0);
    upd_nxt = fld[KEY_S].seen && !fld[KEY_S].neg && (fld[KEY_S].mag == MAG_W'(1));
    press_nxt = press_r;
    if (trk_clear && upd_nxt) begin
      if (!fld[KEY_A].seen || fld[KEY_A].neg) begin
        press_nxt = '0;
      end else if (fld[KEY_A].mag > MAG_W'(PRS_MAX)) begin
        press_nxt = PRS_MAX;
      end else begin
        press_nxt = fld[KEY_A].mag[PRS_W-1:0];
      end
    end
    if (trk_clear) begin
      pos_nxt = '0;
    end else if (s_go && (pos_r != POS_MAX)) begin
      pos_nxt = pos_r + 1'b1;
    end else begin
      pos_nxt = pos_r;
    end
    if (trk_clear) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      press_r     <= PRS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      press_r     <= press_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (trk_clear) begin
      hs_r  <= hs_nxt;
      rq_r  <= rq_nxt;
      upd_r <= upd_nxt;
    end
  end

  // result port
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, press_r, upd_r, rq_r, hs_r};

  // block checks
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (s_go && !s_end) |=> (out_valid_r == $past(out_valid_r && !out_tready)))
    else $error("result raised by an ordinary character");
  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    trk_clear |=> (pos_r == '0))
    else $error("line position not cleared at line end");
  a_press_only_upd: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (press_r != $past(press_r))) |-> (out_valid_r && upd_r))
    else $error("pressure setting changed without update");

endmodule

`default_nettype wire
